@@ rtl/mapct_pkg.sv @@
// shared types and constants of the median moisture block
`timescale 1ns / 1ps
package mapct_pkg;

  // field widths
  localparam int unsigned SMP_W      = 12;
  localparam int unsigned VOLT_W     = 13;
  localparam int unsigned MOIST_W    = 14;
  localparam int unsigned CNT_CFG_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // serial divider widths
  localparam int unsigned DIV_W = 26;
  localparam int unsigned DEN_W = 12;

  // arithmetic constants
  localparam logic [SMP_W-1:0]   ADC_FULL_SCALE = 12'd4095;
  localparam logic [MOIST_W-1:0] PCT_SCALE      = 14'd10000;

  // register reset values
  localparam logic [SMP_W-1:0]     DRY_RST   = 12'd4095;
  localparam logic [SMP_W-1:0]     WET_RST   = 12'd0;
  localparam logic [VOLT_W-1:0]    VREF_RST  = 13'd3300;
  localparam logic [CNT_CFG_W-1:0] COUNT_RST = 5'd30;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRY   = 2'd0,
    REG_WET   = 2'd1,
    REG_VREF  = 2'd2,
    REG_COUNT = 2'd3
  } cfg_reg_e;

  // selection unit response
  typedef struct packed {
    logic             done;
    logic [SMP_W-1:0] median;
  } sel_rsp_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/mapct_if.sv @@
// channel interfaces: sample input, result output, configuration write
`timescale 1ns / 1ps
interface mapct_in_if;
  logic                        valid;
  logic                        ready;
  logic [mapct_pkg::SMP_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface mapct_out_if;
  logic                          valid;
  logic                          ready;
  logic [mapct_pkg::SMP_W-1:0]   median_adc;
  logic [mapct_pkg::VOLT_W-1:0]  voltage_mv;
  logic [mapct_pkg::MOIST_W-1:0] moisture_hundredths;

  modport source (output valid, output median_adc, output voltage_mv,
                  output moisture_hundredths, input ready);
  modport sink   (input valid, input median_adc, input voltage_mv,
                  input moisture_hundredths, output ready);
endinterface

interface mapct_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mapct_pkg::CFG_IDX_W-1:0]  index;
  logic [mapct_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/mapct_div.sv @@
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mapct_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mapct_pkg::div_req_t req_i,
  output mapct_pkg::div_rsp_t rsp_o
);

  localparam int unsigned STEP_W = $clog2(mapct_pkg::DIV_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(mapct_pkg::DIV_W - 1);

  logic                            busy_q;
  logic                            done_q;
  logic [STEP_W-1:0]               step_q;
  logic [mapct_pkg::DEN_W-1:0]     rem_q;
  logic [mapct_pkg::DEN_W-1:0]     den_q;
  logic [mapct_pkg::DIV_W-1:0]     quo_q;
  logic [mapct_pkg::DEN_W:0]       rem_sh;
  logic                            fits;
  logic [mapct_pkg::DEN_W:0]       rem_sub;

  // trial subtract of the shifted remainder
  assign rem_sh  = {rem_q, quo_q[mapct_pkg::DIV_W-1]};
  assign fits    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[mapct_pkg::DIV_W-2:0], fits};
      rem_q <= fits ? rem_sub[mapct_pkg::DEN_W-1:0] : rem_sh[mapct_pkg::DEN_W-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ rtl/mapct_select.sv @@
// window memory and rank search for the upper median
`timescale 1ns / 1ps
module mapct_select #(
  parameter int unsigned MAX_SAMPLES = 30,
  parameter int unsigned IDX_W       = 5,
  parameter int unsigned LEN_W       = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [IDX_W-1:0]            wr_addr_i,
  input  logic [mapct_pkg::SMP_W-1:0] wr_data_i,
  input  logic                        start_i,
  input  logic [LEN_W-1:0]            len_i,
  input  logic [LEN_W-1:0]            target_i,
  output mapct_pkg::sel_rsp_t         rsp_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [mapct_pkg::SMP_W-1:0] mem [MAX_SAMPLES];
  logic [mapct_pkg::SMP_W-1:0] rd_q;
  logic [IDX_W-1:0]            rd_addr;

  logic [1:0]                  state_q;
  logic [IDX_W-1:0]            cand_idx_q;
  logic [IDX_W-1:0]            scan_idx_q;
  logic [IDX_W-1:0]            data_idx_q;
  logic                        data_vld_q;
  logic [LEN_W-1:0]            len_q;
  logic [LEN_W-1:0]            tgt_q;
  logic [LEN_W-1:0]            rank_q;
  logic [mapct_pkg::SMP_W-1:0] cand_q;
  logic                        below;
  logic [LEN_W-1:0]            rank_fin;
  logic                        found;

  // window memory, one write and one registered read per cycle
  assign rd_addr = (state_q == S_LOAD) ? cand_idx_q : scan_idx_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr];
  end

  // entry ranks below the candidate, ties broken by position
  assign below    = (rd_q < cand_q) || ((rd_q == cand_q) && (data_idx_q < cand_idx_q));
  assign rank_fin = rank_q + LEN_W'(below);
  assign found    = (state_q == S_DRAIN) && (rank_fin == tgt_q);

  // candidate and scan sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cand_idx_q <= '0;
      scan_idx_q <= '0;
      data_idx_q <= '0;
      data_vld_q <= 1'b0;
      len_q      <= '0;
      tgt_q      <= '0;
      rank_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            len_q      <= len_i;
            tgt_q      <= target_i;
            cand_idx_q <= '0;
            state_q    <= S_LOAD;
          end
        end
        S_LOAD: begin
          scan_idx_q <= '0;
          data_vld_q <= 1'b0;
          rank_q     <= '0;
          state_q    <= S_SCAN;
        end
        S_SCAN: begin
          if (data_vld_q) begin
            rank_q <= rank_fin;
          end
          data_vld_q <= 1'b1;
          data_idx_q <= scan_idx_q;
          if (LEN_W'(scan_idx_q) == len_q - 1'b1) begin
            state_q <= S_DRAIN;
          end else begin
            scan_idx_q <= scan_idx_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (found) begin
            state_q <= S_IDLE;
          end else begin
            cand_idx_q <= cand_idx_q + 1'b1;
            state_q    <= S_LOAD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // first read of a scan returns the candidate itself
  always_ff @(posedge clk_i) begin
    if ((state_q == S_SCAN) && !data_vld_q) begin
      cand_q <= rd_q;
    end
  end

  assign rsp_o.done   = found;
  assign rsp_o.median = cand_q;

endmodule

@@ rtl/median_adc_moisture_percent_top.sv @@
// top level: median of an adc window with two-point moisture calibration
//
//   port      dir   role      payload
//   cfg_i     in    write     index, data (dry, wet, vref, sample count)
//   sample_i  in    samples   adc_sample
//   result_o  out   results   median_adc, voltage_mv, moisture_hundredths
//
// a sample that does not complete the window is stored and the sample side stays ready
// the window-closing sample runs a rank search over the window memory,
// trying each window slot as candidate with a load, a scan of the window
// and a drain up to the slot that holds the median, then a multiply, voltage
// scaling and a serial divide, skipped when the calibration forces zero moisture
// the single read port of the window memory sets the search length
// reset clears counters and control; the window memory is not cleared
// a stalled result sits in the output register while the next samples go in
`timescale 1ns / 1ps
module median_adc_moisture_percent_top #(
  parameter int unsigned MAX_SAMPLES = 30
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mapct_cfg_if.sink      cfg_i,
  mapct_in_if.sink       sample_i,
  mapct_out_if.source    result_o
);

  localparam int unsigned IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned CW    = (LEN_W > mapct_pkg::CNT_CFG_W) ? LEN_W
                                                                 : mapct_pkg::CNT_CFG_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEL  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIVV = 3'd3;
  localparam logic [2:0] ST_DIVM = 3'd4;
  localparam logic [2:0] ST_RES  = 3'd5;

  // configuration registers
  logic [mapct_pkg::SMP_W-1:0]     dry_q;
  logic [mapct_pkg::SMP_W-1:0]     wet_q;
  logic [mapct_pkg::VOLT_W-1:0]    vref_q;
  logic [mapct_pkg::CNT_CFG_W-1:0] count_q;

  logic [2:0]                      state_q;
  logic [LEN_W-1:0]                coll_q;
  logic [mapct_pkg::SMP_W-1:0]     med_q;
  logic [24:0]                     prod_v_q;
  logic                            zero_q;
  logic [mapct_pkg::VOLT_W-1:0]    volt_q;
  logic [mapct_pkg::MOIST_W-1:0]   moist_q;

  logic                            out_vld_q;
  logic [mapct_pkg::SMP_W-1:0]     out_med_q;
  logic [mapct_pkg::VOLT_W-1:0]    out_volt_q;
  logic [mapct_pkg::MOIST_W-1:0]   out_moist_q;

  logic                            in_acc;
  logic [CW-1:0]                   cnt_ext;
  logic [CW-1:0]                   len_ext;
  logic [LEN_W-1:0]                win_len;
  logic [LEN_W-1:0]                pos;
  logic                            win_last;
  logic                            out_load;

  logic [24:0]                     prod_v;
  logic [12:0]                     v_hi;
  logic [13:0]                     v_sum;
  logic [12:0]                     v_fold;
  logic [mapct_pkg::VOLT_W-1:0]    volt_d;
  logic [mapct_pkg::DIV_W-1:0]     prod_m_d;
  logic [mapct_pkg::DEN_W-1:0]     den_d;
  logic [mapct_pkg::SMP_W-1:0]     num_d;
  logic                            zero_d;
  logic [mapct_pkg::MOIST_W-1:0]   moist_clamp;

  mapct_pkg::sel_rsp_t             sel_rsp;
  mapct_pkg::div_req_t             div_req;
  mapct_pkg::div_rsp_t             div_rsp;

  // configuration writes, always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_q   <= mapct_pkg::DRY_RST;
      wet_q   <= mapct_pkg::WET_RST;
      vref_q  <= mapct_pkg::VREF_RST;
      count_q <= mapct_pkg::COUNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mapct_pkg::REG_DRY:   dry_q   <= cfg_i.data[mapct_pkg::SMP_W-1:0];
        mapct_pkg::REG_WET:   wet_q   <= cfg_i.data[mapct_pkg::SMP_W-1:0];
        mapct_pkg::REG_VREF:  vref_q  <= cfg_i.data[mapct_pkg::VOLT_W-1:0];
        mapct_pkg::REG_COUNT: count_q <= cfg_i.data[mapct_pkg::CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // window length and write slot
  assign cnt_ext  = CW'(count_q);
  assign len_ext  = (cnt_ext == '0) ? CW'(1)
                  : ((cnt_ext > CW'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) : cnt_ext);
  assign win_len  = LEN_W'(len_ext);
  assign pos      = (coll_q >= win_len) ? (win_len - 1'b1) : coll_q;
  assign win_last = (pos + 1'b1) >= win_len;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_acc         = sample_i.valid && sample_i.ready;

  mapct_select #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .IDX_W       (IDX_W),
    .LEN_W       (LEN_W)
  ) u_select (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc),
    .wr_addr_i (IDX_W'(pos)),
    .wr_data_i (sample_i.adc_sample),
    .start_i   (in_acc && win_last),
    .len_i     (win_len),
    .target_i  (win_len >> 1),
    .rsp_o     (sel_rsp)
  );

  // calibration: numerator, span and the no-result cases
  always_comb begin
    num_d  = '0;
    den_d  = '0;
    zero_d = 1'b1;
    if (dry_q > wet_q) begin
      num_d  = dry_q - med_q;
      den_d  = dry_q - wet_q;
      zero_d = med_q >= dry_q;
    end else if (wet_q > dry_q) begin
      num_d  = med_q - dry_q;
      den_d  = wet_q - dry_q;
      zero_d = med_q <= dry_q;
    end
  end

  assign prod_v   = 25'(med_q) * 25'(vref_q);
  assign prod_m_d = mapct_pkg::DIV_W'(num_d) * mapct_pkg::DIV_W'(mapct_pkg::PCT_SCALE);

  // voltage: divide by 4095 as x = 4096a + b = 4095a + (a + b), folded twice
  assign v_hi   = prod_v_q[24:12];
  assign v_sum  = {1'b0, v_hi} + {2'b0, prod_v_q[11:0]};
  assign v_fold = {11'b0, v_sum[13:12]} + {1'b0, v_sum[11:0]};
  assign volt_d = v_hi + {11'b0, v_sum[13:12]}
                + {12'b0, (v_fold >= {1'b0, mapct_pkg::ADC_FULL_SCALE})};

  // divider for the moisture quotient
  always_comb begin
    div_req.start    = (state_q == ST_MUL) && !zero_d;
    div_req.dividend = prod_m_d;
    div_req.divisor  = den_d;
  end

  mapct_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign moist_clamp = (div_rsp.quotient > mapct_pkg::DIV_W'(mapct_pkg::PCT_SCALE))
                     ? mapct_pkg::PCT_SCALE
                     : div_rsp.quotient[mapct_pkg::MOIST_W-1:0];

  assign out_load = (state_q == ST_RES) && (!out_vld_q || result_o.ready);

  // sequencer over sample fill, search, multiply and divides
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      coll_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (win_last) begin
              coll_q  <= '0;
              state_q <= ST_SEL;
            end else begin
              coll_q  <= pos + 1'b1;
            end
          end
        end
        ST_SEL:  if (sel_rsp.done) state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_DIVV;
        ST_DIVV: state_q <= zero_q ? ST_RES : ST_DIVM;
        ST_DIVM: if (div_rsp.done) state_q <= ST_RES;
        ST_RES:  if (out_load) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // result datapath
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SEL) && sel_rsp.done) begin
      med_q <= sel_rsp.median;
    end
    if (state_q == ST_MUL) begin
      prod_v_q <= prod_v;
      zero_q   <= zero_d;
    end
    if (state_q == ST_DIVV) begin
      volt_q  <= volt_d;
      moist_q <= '0;
    end
    if ((state_q == ST_DIVM) && div_rsp.done) begin
      moist_q <= moist_clamp;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_med_q   <= med_q;
      out_volt_q  <= volt_q;
      out_moist_q <= moist_q;
    end
  end

  assign result_o.valid               = out_vld_q;
  assign result_o.median_adc          = out_med_q;
  assign result_o.voltage_mv          = out_volt_q;
  assign result_o.moisture_hundredths = out_moist_q;

endmodule

@@ rtl/mapct_chk.sv @@
// port checker for the median moisture block and its bind
`timescale 1ns / 1ps
module mapct_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mapct_pkg::SMP_W-1:0]   median_adc,
  input logic [mapct_pkg::VOLT_W-1:0]  voltage_mv,
  input logic [mapct_pkg::MOIST_W-1:0] moisture_hundredths
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(median_adc)
      && $stable(voltage_mv) && $stable(moisture_hundredths))
    else $error("stalled result changed");

  // moisture never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> moisture_hundredths <= mapct_pkg::PCT_SCALE)
    else $error("moisture above full scale");

  // a new result only follows a busy period of the sample side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while samples were taken");

  // a sample request held off by a busy block reopens only with a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_ready |=> !in_ready || out_valid)
    else $error("sample side reopened without a result");

endmodule

bind median_adc_moisture_percent_top mapct_chk u_mapct_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid            (sample_i.valid),
  .in_ready            (sample_i.ready),
  .out_valid           (result_o.valid),
  .out_ready           (result_o.ready),
  .median_adc          (result_o.median_adc),
  .voltage_mv          (result_o.voltage_mv),
  .moisture_hundredths (result_o.moisture_hundredths)
);
